>>> src/spg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg
// shared types, constants and step functions of the speaker proximity gain block
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int INDEX_W  = 6;
    localparam int SQ_W     = 30;
    localparam int QUOT_W   = 17;

    localparam int ROOT_STEPS  = 15;
    localparam int ROOT_PER_ST = 3;
    localparam int ROOT_STAGES = 5;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_PER_ST  = 3;
    localparam int DIV_STAGES  = 6;

    // lane depth: delta, squares, root stages, divide stages, gain
    localparam int LANE_LAT = 2 + ROOT_STAGES + DIV_STAGES + 1;
    localparam int LANES    = 5;

    localparam logic signed [COORD_W-1:0] HALF_Q   = 16'sd8192;
    localparam logic        [QUOT_W-1:0]  ONE_Q    = 17'd16384;
    localparam logic        [QUOT_W-1:0]  SAT_Q    = 17'd49152;
    localparam logic signed [COORD_W-1:0] GAIN_MIN = 16'sh8000;

    localparam logic [2:0] REG_SOURCE_X    = 3'd0;
    localparam logic [2:0] REG_SOURCE_Y    = 3'd1;
    localparam logic [2:0] REG_SOURCE_Z    = 3'd2;
    localparam logic [2:0] REG_HALF_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HALF_HEIGHT = 3'd4;
    localparam logic [2:0] REG_DIFFUSE     = 3'd5;

    typedef struct packed {
        logic [17:0]         r;
        logic [RADIUS_W-1:0] y;
        logic [SQ_W-1:0]     v;
        logic [SQ_W-1:0]     m;
        logic                excl;
    } root_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [SQ_W-1:0]   m;
        logic [QUOT_W-1:0] q;
        logic              sat;
        logic              excl;
    } div_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               diffuse;
    } side_t;

    // one digit of the square root, two radicand bits a step
    function automatic root_t root_step(input root_t a);
        root_t       b;
        logic [17:0] rr;
        logic [17:0] t;
        b  = a;
        rr = {a.r[15:0], a.v[SQ_W-1:SQ_W-2]};
        t  = {1'b0, a.y, 2'b01};
        b.v = {a.v[SQ_W-3:0], 2'b00};
        if (rr >= t)
        begin
            b.r = rr - t;
            b.y = {a.y[RADIUS_W-2:0], 1'b1};
        end
        else
        begin
            b.r = rr;
            b.y = {a.y[RADIUS_W-2:0], 1'b0};
        end
        return b;
    endfunction

    // one restoring division step
    function automatic div_t div_step(input div_t a);
        div_t          b;
        logic [SQ_W:0] t;
        logic [SQ_W:0] d;
        b = a;
        t = {a.rem, 1'b0};
        d = t - {1'b0, a.m};
        if (t >= {1'b0, a.m})
        begin
            b.rem = d[SQ_W-1:0];
            b.q   = {a.q[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            b.rem = t[SQ_W-1:0];
            b.q   = {a.q[QUOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

>>> src/spg_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_root
// pipelined integer square root, three digits per stage
// ----------------------------------------------------------------------------
module spg_root (
    input  logic          clk,
    input  logic          en,
    input  spg_pkg::root_t init,
    output spg_pkg::root_t result
);

    spg_pkg::root_t st_reg  [spg_pkg::ROOT_STAGES];
    spg_pkg::root_t st_next [spg_pkg::ROOT_STAGES];

    for (genvar s = 0; s < spg_pkg::ROOT_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            spg_pkg::root_t cur;
            cur = (s == 0) ? init : st_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < spg_pkg::ROOT_PER_ST; j++)
            begin
                if (s * spg_pkg::ROOT_PER_ST + j < spg_pkg::ROOT_STEPS)
                begin
                    cur = spg_pkg::root_step(cur);
                end
            end
            st_next[s] = cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign result = st_reg[spg_pkg::ROOT_STAGES-1];

endmodule

>>> src/spg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_div
// pipelined restoring divider, three quotient bits per stage, two in the last
// ----------------------------------------------------------------------------
module spg_div (
    input  logic         clk,
    input  logic         en,
    input  spg_pkg::div_t init,
    output spg_pkg::div_t result
);

    spg_pkg::div_t st_reg  [spg_pkg::DIV_STAGES];
    spg_pkg::div_t st_next [spg_pkg::DIV_STAGES];

    for (genvar s = 0; s < spg_pkg::DIV_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            spg_pkg::div_t cur;
            cur = (s == 0) ? init : st_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < spg_pkg::DIV_PER_ST; j++)
            begin
                if (s * spg_pkg::DIV_PER_ST + j < spg_pkg::DIV_STEPS)
                begin
                    cur = spg_pkg::div_step(cur);
                end
            end
            st_next[s] = cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign result = st_reg[spg_pkg::DIV_STAGES-1];

endmodule

>>> src/spg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_lane
// gain of one source point for one speaker: deltas, squares, root, divide
// ----------------------------------------------------------------------------
module spg_lane (
    input  logic                clk,
    input  logic                en,
    input  logic signed [16:0]  qx,
    input  logic signed [16:0]  qy,
    input  logic signed [16:0]  qz,
    input  logic signed [15:0]  px,
    input  logic signed [15:0]  py,
    input  logic signed [15:0]  pz,
    input  logic        [14:0]  rh,
    input  logic        [14:0]  rv,
    output logic signed [15:0]  gain
);

    logic signed [17:0] ddx, ddy, ddz;
    logic        [17:0] adx, ady, adz;
    logic               excl1_next;

    logic [14:0] dx_reg, dy_reg, dz_reg, rh_reg, rv_reg;
    logic        excl1_reg;

    logic [29:0] dxx, dyy, dzz, rh2_next, rhrv_next;
    logic [31:0] sum_next;
    logic [31:0] sum_reg;
    logic [29:0] rh2_reg, rhrv_reg;
    logic        excl2_reg;

    spg_pkg::root_t root_init, root_res;
    spg_pkg::div_t  div_init, div_res;
    logic [29:0]    shifted_root;

    logic signed [15:0] gain_next;
    logic signed [15:0] gain_reg;
    logic        [16:0] diff;

    // absolute axis distances
    assign ddx = 18'(qx) - 18'(px);
    assign ddy = 18'(qy) - 18'(py);
    assign ddz = 18'(qz) - 18'(pz);
    assign adx = ddx[17] ? 18'(-ddx) : 18'(ddx);
    assign ady = ddy[17] ? 18'(-ddy) : 18'(ddy);
    assign adz = ddz[17] ? 18'(-ddz) : 18'(ddz);

    assign excl1_next = (rh == '0) || (rv == '0) || (adx > {3'b0, rh})
                     || (ady > {3'b0, rh}) || (adz > {3'b0, rv});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= adx[14:0];
            dy_reg    <= ady[14:0];
            dz_reg    <= adz[14:0];
            rh_reg    <= rh;
            rv_reg    <= rv;
            excl1_reg <= excl1_next;
        end
    end

    // squares and radius products
    assign dxx       = dx_reg * dx_reg;
    assign dyy       = dy_reg * dy_reg;
    assign dzz       = dz_reg * dz_reg;
    assign rh2_next  = rh_reg * rh_reg;
    assign rhrv_next = rh_reg * rv_reg;
    assign sum_next  = {2'b0, dxx} + {2'b0, dyy} + {2'b0, dzz};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_next;
            rh2_reg   <= rh2_next;
            rhrv_reg  <= rhrv_next;
            excl2_reg <= excl1_reg;
        end
    end

    always_comb
    begin
        root_init      = '0;
        root_init.v    = sum_reg[29:0];
        root_init.m    = rhrv_reg;
        root_init.excl = excl2_reg || (sum_reg > {2'b0, rh2_reg});
    end

    spg_root u_root (
        .clk    (clk),
        .en     (en),
        .init   (root_init),
        .result (root_res)
    );

    // quotient overflows 17 bits when root * 2^11 reaches the divisor
    assign shifted_root = {4'b0, root_res.y, 11'b0};

    always_comb
    begin
        div_init      = '0;
        div_init.rem  = shifted_root;
        div_init.m    = root_res.m;
        div_init.sat  = (shifted_root >= root_res.m);
        div_init.excl = root_res.excl;
    end

    spg_div u_div (
        .clk    (clk),
        .en     (en),
        .init   (div_init),
        .result (div_res)
    );

    assign diff = spg_pkg::ONE_Q - div_res.q;

    always_comb
    begin
        if (div_res.excl)
        begin
            gain_next = '0;
        end
        else if (div_res.sat || (div_res.q > spg_pkg::SAT_Q))
        begin
            gain_next = spg_pkg::GAIN_MIN;
        end
        else
        begin
            gain_next = signed'(diff[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

>>> src/speaker_proximity_gain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speaker_proximity_gain_top
// loudspeaker gain for a virtual source, with optional five point diffusion
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the output is not held; five point lanes run side by side
// the pipeline depth is set by the 15 digit root and 17 bit quotient
// a stalled output freezes the whole pipeline, nothing is dropped
// reset: control and valid bits clear asynchronously, source at 0.5, diffuse off
module speaker_proximity_gain_top (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // speaker requests
    input  logic               speaker_valid,
    output logic               speaker_stall,
    input  logic [5:0]         speaker_index,
    input  logic signed [15:0] speaker_x,
    input  logic signed [15:0] speaker_y,
    input  logic signed [15:0] speaker_z,
    input  logic [14:0]        horizontal_radius,
    input  logic [14:0]        vertical_radius,
    input  logic               last_speaker,
    // gain results
    output logic               gain_valid,
    input  logic               gain_stall,
    output logic [5:0]         gain_index,
    output logic signed [15:0] gain,
    output logic               gain_last
);

    // configuration registers
    logic signed [15:0] source_x_reg, source_y_reg, source_z_reg;
    logic        [14:0] half_width_reg, half_height_reg;
    logic               diffuse_reg;
    logic        [2:0]  reg_sel;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_x_reg    <= spg_pkg::HALF_Q;
            source_y_reg    <= spg_pkg::HALF_Q;
            source_z_reg    <= spg_pkg::HALF_Q;
            half_width_reg  <= '0;
            half_height_reg <= '0;
            diffuse_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                spg_pkg::REG_SOURCE_X:    source_x_reg    <= signed'(pwdata[15:0]);
                spg_pkg::REG_SOURCE_Y:    source_y_reg    <= signed'(pwdata[15:0]);
                spg_pkg::REG_SOURCE_Z:    source_z_reg    <= signed'(pwdata[15:0]);
                spg_pkg::REG_HALF_WIDTH:  half_width_reg  <= pwdata[14:0];
                spg_pkg::REG_HALF_HEIGHT: half_height_reg <= pwdata[14:0];
                spg_pkg::REG_DIFFUSE:     diffuse_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_sel)
            spg_pkg::REG_SOURCE_X:    prdata = 32'(unsigned'(source_x_reg));
            spg_pkg::REG_SOURCE_Y:    prdata = 32'(unsigned'(source_y_reg));
            spg_pkg::REG_SOURCE_Z:    prdata = 32'(unsigned'(source_z_reg));
            spg_pkg::REG_HALF_WIDTH:  prdata = {17'b0, half_width_reg};
            spg_pkg::REG_HALF_HEIGHT: prdata = {17'b0, half_height_reg};
            spg_pkg::REG_DIFFUSE:     prdata = {31'b0, diffuse_reg};
            default:                  prdata = '0;
        endcase
    end

    // pipeline advance: everything moves unless a finished gain is held
    logic en;
    logic out_valid_reg;

    assign en            = !(out_valid_reg && gain_stall);
    assign speaker_stall = !en;

    // the five source points: centre, north, south, east, west
    logic signed [16:0] sx, sy, sz, hw, hh, hz;
    logic signed [16:0] qx [spg_pkg::LANES];
    logic signed [16:0] qy [spg_pkg::LANES];
    logic signed [16:0] qz [spg_pkg::LANES];

    assign sx = 17'(source_x_reg);
    assign sy = 17'(source_y_reg);
    assign sz = 17'(source_z_reg);
    assign hw = signed'({2'b0, half_width_reg});
    assign hh = signed'({2'b0, half_height_reg});
    assign hz = 17'(spg_pkg::HALF_Q);

    assign qx[0] = sx;      assign qy[0] = sy;      assign qz[0] = sz;
    assign qx[1] = sx;      assign qy[1] = sy + hh; assign qz[1] = hz;
    assign qx[2] = sx;      assign qy[2] = sy - hh; assign qz[2] = hz;
    assign qx[3] = sx + hw; assign qy[3] = sy;      assign qz[3] = hz;
    assign qx[4] = sx - hw; assign qy[4] = sy;      assign qz[4] = hz;

    logic signed [15:0] lane_gain [spg_pkg::LANES];

    for (genvar l = 0; l < spg_pkg::LANES; l++)
    begin : g_lane
        spg_lane u_lane (
            .clk  (clk),
            .en   (en),
            .qx   (qx[l]),
            .qy   (qy[l]),
            .qz   (qz[l]),
            .px   (speaker_x),
            .py   (speaker_y),
            .pz   (speaker_z),
            .rh   (horizontal_radius),
            .rv   (vertical_radius),
            .gain (lane_gain[l])
        );
    end

    // valid bits and side data travel alongside the lanes
    logic           v_reg    [spg_pkg::LANE_LAT];
    spg_pkg::side_t side_reg [spg_pkg::LANE_LAT];
    spg_pkg::side_t side_in;

    assign side_in = '{index: speaker_index, last: last_speaker, diffuse: diffuse_reg};

    for (genvar s = 0; s < spg_pkg::LANE_LAT; s++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= (s == 0) ? speaker_valid : v_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // diffuse maximum, signed compare
    logic signed [15:0] m01, m23, m03, gmax, gain_next;
    logic signed [15:0] gain_reg;
    logic        [5:0]  index_reg;
    logic               last_reg;
    spg_pkg::side_t     side_end;

    assign side_end  = side_reg[spg_pkg::LANE_LAT-1];
    assign m01       = (lane_gain[1] > lane_gain[0]) ? lane_gain[1] : lane_gain[0];
    assign m23       = (lane_gain[3] > lane_gain[2]) ? lane_gain[3] : lane_gain[2];
    assign m03       = (m23 > m01) ? m23 : m01;
    assign gmax      = (lane_gain[4] > m03) ? lane_gain[4] : m03;
    assign gain_next = side_end.diffuse ? gmax : lane_gain[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[spg_pkg::LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg  <= gain_next;
            index_reg <= side_end.index;
            last_reg  <= side_end.last;
        end
    end

    assign gain_valid = out_valid_reg;
    assign gain       = gain_reg;
    assign gain_index = index_reg;
    assign gain_last  = last_reg;

endmodule

>>> src/spg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_checker
// port level checks of the speaker proximity gain block
// ----------------------------------------------------------------------------
module spg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pready,
    input  logic               speaker_stall,
    input  logic               gain_valid,
    input  logic               gain_stall,
    input  logic [5:0]         gain_index,
    input  logic signed [15:0] gain
);

    // a held gain stays valid and unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        gain_valid && gain_stall |=> gain_valid && $stable(gain) && $stable(gain_index))
        else $error("held gain changed");

    // the input is only stalled by a held output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        speaker_stall |-> gain_valid && gain_stall)
        else $error("input stalled without a held gain");

    // once neither side stalls, a later input stall comes only with a valid gain
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !gain_stall && !speaker_stall |=> !speaker_stall || gain_valid)
        else $error("stall without pending gain");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind speaker_proximity_gain_top spg_checker u_spg_checker (.*);

>>> bench/tb_speaker_proximity_gain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speaker_proximity_gain_top
// self-checking bench for the speaker proximity gain block
// ----------------------------------------------------------------------------
// a local gain predictor follows every accepted speaker request. Each gain
// result is compared field by field against the oldest predicted gain.
// The run goes through directed corner cases, random source settings,
// a long output hold-off, a full drain pause and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_speaker_proximity_gain_top;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // configuration port, idle from time zero
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // speaker request channel
    logic               speaker_valid     = 1'b0;
    logic               speaker_stall;
    logic [5:0]         speaker_index     = '0;
    logic signed [15:0] speaker_x         = '0;
    logic signed [15:0] speaker_y         = '0;
    logic signed [15:0] speaker_z         = '0;
    logic [14:0]        horizontal_radius = '0;
    logic [14:0]        vertical_radius   = '0;
    logic               last_speaker      = 1'b0;

    // gain result channel
    logic               gain_valid;
    logic               gain_stall = 1'b0;
    logic [5:0]         gain_index;
    logic signed [15:0] gain;
    logic               gain_last;

    speaker_proximity_gain_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .speaker_valid     (speaker_valid),
        .speaker_stall     (speaker_stall),
        .speaker_index     (speaker_index),
        .speaker_x         (speaker_x),
        .speaker_y         (speaker_y),
        .speaker_z         (speaker_z),
        .horizontal_radius (horizontal_radius),
        .vertical_radius   (vertical_radius),
        .last_speaker      (last_speaker),
        .gain_valid        (gain_valid),
        .gain_stall        (gain_stall),
        .gain_index        (gain_index),
        .gain              (gain),
        .gain_last         (gain_last)
    );

    typedef struct {
        logic [5:0]         index;
        logic signed [15:0] value;
        logic               last;
    } gain_item_t;

    // predicted gains waiting for their result
    gain_item_t pending_gains[$];

    // local copy of the source registers
    longint src_x;
    longint src_y;
    longint src_z;
    longint half_w;
    longint half_h;
    bit     diffuse;

    int  error_count   = 0;
    int  request_count = 0;
    int  gain_count    = 0;
    int  config_count  = 0;
    bit  tx_idle_en    = 1'b1;
    bit  rx_idle_en    = 1'b1;
    int  hold_token    = 0;

    // ------------------------------------------------------------------------
    // gain predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint abs_dist(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // gain of one source point, excluded points give zero
    function automatic longint point_gain(input longint qx, input longint qy,
                                          input longint qz, input longint px,
                                          input longint py, input longint pz,
                                          input longint rh, input longint rv);
        longint dx;
        longint dy;
        longint dz;
        longint sum;
        longint root;
        longint quot;
        if (rh == 0 || rv == 0)
            return 0;
        dx = abs_dist(qx, px);
        dy = abs_dist(qy, py);
        dz = abs_dist(qz, pz);
        if (dx > rh || dy > rh || dz > rv)
            return 0;
        sum = dx * dx + dy * dy + dz * dz;
        if (sum > rh * rh)
            return 0;
        root = longint'(int_sqrt(longint'(sum)));
        quot = (root <<< 28) / (rh * rv);
        if (quot > 49152)
            return -32768;
        return 16384 - quot;
    endfunction

    function automatic logic signed [15:0] speaker_gain(input longint px,
                                                        input longint py,
                                                        input longint pz,
                                                        input longint rh,
                                                        input longint rv);
        longint best;
        longint t;
        best = point_gain(src_x, src_y, src_z, px, py, pz, rh, rv);
        if (diffuse)
        begin
            // north, south, east, west at half height
            t = point_gain(src_x, src_y + half_h, 8192, px, py, pz, rh, rv);
            if (t > best) best = t;
            t = point_gain(src_x, src_y - half_h, 8192, px, py, pz, rh, rv);
            if (t > best) best = t;
            t = point_gain(src_x + half_w, src_y, 8192, px, py, pz, rh, rv);
            if (t > best) best = t;
            t = point_gain(src_x - half_w, src_y, 8192, px, py, pz, rh, rv);
            if (t > best) best = t;
        end
        if (best > 32767)
            best = 32767;
        return best[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts and a long hold-off on request
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    int hold_seen  = 0;

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            // long hold-off so the pipeline fills and stalls its input
            hold_seen  = hold_token;
            hold_left  = 300;
        end
        if (hold_left > 0)
        begin
            gain_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            gain_stall <= 1'b1;
            stall_left--;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            gain_stall <= 1'b1;
            stall_left = $urandom_range(0, 12);
        end
        else
            gain_stall <= 1'b0;
    end

    // result checker, compares against the oldest predicted gain
    always @(posedge clk)
    begin
        gain_item_t exp_gain;
        if (rst_n && gain_valid && !gain_stall)
        begin
            gain_count++;
            if (pending_gains.size() == 0)
                report_mismatch("gain result with no request outstanding");
            else
            begin
                exp_gain = pending_gains.pop_front();
                if (gain_index !== exp_gain.index)
                    report_mismatch($sformatf("gain_index %0d expected %0d",
                                              gain_index, exp_gain.index));
                if (gain !== exp_gain.value)
                    report_mismatch($sformatf("gain %0d expected %0d (index %0d)",
                                              gain, exp_gain.value, exp_gain.index));
                if (gain_last !== exp_gain.last)
                    report_mismatch($sformatf("gain_last %0b expected %0b",
                                              gain_last, exp_gain.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // called just after a rising edge, returns just after the accepting edge or after a random idle gap
    task automatic send_request(input logic [5:0] idx, input longint px,
                                input longint py, input longint pz,
                                input longint rh, input longint rv,
                                input bit last);
        gain_item_t exp_gain;
        speaker_valid     <= 1'b1;
        speaker_index     <= idx;
        speaker_x         <= px[15:0];
        speaker_y         <= py[15:0];
        speaker_z         <= pz[15:0];
        horizontal_radius <= rh[14:0];
        vertical_radius   <= rv[14:0];
        last_speaker      <= last;
        @(posedge clk);
        while (speaker_stall)
            @(posedge clk);
        exp_gain.index = idx;
        exp_gain.value = speaker_gain(px, py, pz, rh, rv);
        exp_gain.last  = last;
        pending_gains.insert(pending_gains.size(), exp_gain);
        request_count++;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            speaker_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // wait until every gain is back, then let the pipeline settle
    task automatic drain_results();
        speaker_valid <= 1'b0;
        @(posedge clk);
        while (pending_gains.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // setup and access cycle on the configuration port, block must be idle
    task automatic write_reg(input logic [2:0] idx, input longint value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_count++;
        case (idx)
            spg_pkg::REG_SOURCE_X:    src_x   = value;
            spg_pkg::REG_SOURCE_Y:    src_y   = value;
            spg_pkg::REG_SOURCE_Z:    src_z   = value;
            spg_pkg::REG_HALF_WIDTH:  half_w  = value;
            spg_pkg::REG_HALF_HEIGHT: half_h  = value;
            spg_pkg::REG_DIFFUSE:     diffuse = value[0];
            default: ;
        endcase
    endtask

    task automatic set_source(input longint x, input longint y, input longint z,
                              input longint hw, input longint hh, input bit dif);
        write_reg(spg_pkg::REG_SOURCE_X, x);
        write_reg(spg_pkg::REG_SOURCE_Y, y);
        write_reg(spg_pkg::REG_SOURCE_Z, z);
        write_reg(spg_pkg::REG_HALF_WIDTH, hw);
        write_reg(spg_pkg::REG_HALF_HEIGHT, hh);
        write_reg(spg_pkg::REG_DIFFUSE, longint'(dif));
    endtask

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint rand_coord();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    // radius picked from small, mid and full ranges
    function automatic longint rand_radius();
        case ($urandom_range(0, 5))
            0:       return longint'($urandom_range(0, 3));
            1:       return longint'($urandom_range(0, 255));
            2:       return 32767;
            default: return longint'($urandom_range(0, 32767));
        endcase
    endfunction

    // speaker placed near one of the source points so most land in range
    task automatic send_random_speaker();
        longint rh;
        longint rv;
        longint cx;
        longint cy;
        longint cz;
        rh = rand_radius();
        rv = rand_radius();
        if ($urandom_range(0, 4) == 0)
            send_request(6'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                         rand_coord(), rh, rv, 1'($urandom_range(0, 1)));
        else
        begin
            cx = src_x;
            cy = src_y;
            cz = src_z;
            case ($urandom_range(0, 4))
                1: begin cy = src_y + half_h; cz = 8192; end
                2: begin cy = src_y - half_h; cz = 8192; end
                3: begin cx = src_x + half_w; cz = 8192; end
                4: begin cx = src_x - half_w; cz = 8192; end
                default: ;
            endcase
            send_request(6'($urandom_range(0, 63)),
                         clip16(cx + longint'($urandom_range(0, 2 * rh + 2)) - rh - 1),
                         clip16(cy + longint'($urandom_range(0, 2 * rh + 2)) - rh - 1),
                         clip16(cz + longint'($urandom_range(0, 2 * rv + 2)) - rv - 1),
                         rh, rv, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_source();
        longint sx;
        longint sy;
        longint sz;
        longint hw;
        longint hh;
        sx = ($urandom_range(0, 5) == 0) ? 32767 : rand_coord();
        sy = ($urandom_range(0, 5) == 0) ? -32768 : rand_coord();
        sz = ($urandom_range(0, 3) == 0) ? 8192 : rand_coord();
        hw = ($urandom_range(0, 5) == 0) ? 32767 : longint'($urandom_range(0, 4095));
        hh = ($urandom_range(0, 5) == 0) ? 0 : longint'($urandom_range(0, 32767));
        set_source(sx, sy, sz, hw, hh, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // reset source values, speaker right on the source
        send_request(6'd0, 8192, 8192, 8192, 32767, 32767, 1'b0);
        send_request(6'd63, 8192, 8192, 8192, 16384, 16384, 1'b1);
        // zero radii on either axis
        send_request(6'd1, 8192, 8192, 8192, 0, 16384, 1'b0);
        send_request(6'd2, 8192, 8192, 8192, 16384, 0, 1'b0);
        // one axis just past its radius, exactly on it, then past the vertical radius
        send_request(6'd3, 8192 + 101, 8192, 8192, 100, 200, 1'b0);
        send_request(6'd4, 8192, 8192 + 100, 8192, 100, 200, 1'b0);
        send_request(6'd5, 8192, 8192, 8192 - 201, 100, 200, 1'b0);
        // inside every box but outside the sphere
        send_request(6'd6, 8192 + 90, 8192 + 90, 8192, 100, 200, 1'b0);
        // tiny radii force the saturated negative gain
        send_request(6'd7, 8192 + 1, 8192, 8192, 2, 1, 1'b0);
        // coordinate extremes against the full radius
        send_request(6'd8, 32767, -32768, 32767, 32767, 32767, 1'b1);
        send_request(6'd9, -32768, 32767, -32768, 32767, 32767, 1'b0);
        drain_results();
        set_source(-32768, 32767, 0, 32767, 32767, 1'b1);
        send_request(6'd10, -32768, 32767, 0, 32767, 32767, 1'b0);
        send_request(6'd11, 0, 0, 8192, 32767, 32767, 1'b1);
        drain_results();
        // negative gain at an offset point masked by an excluded centre
        set_source(0, 0, 0, 0, 0, 1'b1);
        send_request(6'd12, 0, 40, 8192, 64, 64, 1'b0);
        send_request(6'd13, 0, 0, 8192, 64, 64, 1'b1);
        drain_results();
        // diffuse with offsets, speaker at the east, north, south and west points
        set_source(1000, -1000, 0, 3000, 2000, 1'b1);
        send_request(6'd14, 4000, -1000, 8192, 500, 400, 1'b0);
        send_request(6'd15, 1000, 1000, 8192, 500, 400, 1'b0);
        send_request(6'd16, 1000, -3000, 8192, 500, 400, 1'b1);
        send_request(6'd17, -2000, -1000, 8192, 500, 400, 1'b0);
        drain_results();
    endtask

    task automatic test_random_sources(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            random_source();
            for (int i = 0; i < per_phase; i++)
                send_random_speaker();
            drain_results();
        end
    endtask

    // output held off while the sender keeps offering
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_token++;
        for (int i = 0; i < 80; i++)
            send_random_speaker();
        tx_idle_en = 1'b1;
        drain_results();
    endtask

    // sender pauses mid-stream until every gain has come back
    task automatic test_drain_pause();
        for (int i = 0; i < 40; i++)
            send_random_speaker();
        speaker_valid <= 1'b0;
        @(posedge clk);
        while (pending_gains.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 40; i++)
            send_random_speaker();
        drain_results();
    endtask

    // back to back requests, no idling on either side
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_source(8192, 8192, 8192, 4000, 4000, 1'b1);
        for (int i = 0; i < 150; i++)
            send_random_speaker();
        drain_results();
    endtask

    initial
    begin
        src_x   = 8192;
        src_y   = 8192;
        src_z   = 8192;
        half_w  = 0;
        half_h  = 0;
        diffuse = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_sources(16, 90);
        test_backpressure();
        test_drain_pause();
        test_random_sources(4, 20);
        test_full_rate();

        repeat (30) @(posedge clk);
        $display("covered %0d speaker requests, %0d gains, %0d register writes",
                 request_count, gain_count, config_count);
        $display("incl. zero radii, exclusions, saturation, diffuse maximum, backpressure");
        if (error_count == 0 && pending_gains.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("timeout waiting for gain results");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
